@@ hdl/sdpr_pkg.sv @@
`timescale 1ns / 1ps

package sdpr_pkg;

	localparam int unsigned BLOCK_SIZE_W = 10;
	localparam int unsigned RETRY_W      = 8;
	localparam int unsigned CRC_W        = 16;
	localparam int unsigned PADDR_W      = 3;
	localparam int unsigned PDATA_W      = 32;

	localparam logic [BLOCK_SIZE_W-1:0] MAX_BLOCK_BYTES   = 10'd512;
	localparam logic [BLOCK_SIZE_W-1:0] RESET_BLOCK_SIZE  = 10'd512;
	localparam logic [RETRY_W-1:0]      RESET_RETRY_LIMIT = 8'd100;

	localparam logic [7:0] TOKEN_START    = 8'hFE;
	localparam logic [7:0] FILLER         = 8'hFF;
	localparam logic [7:0] ERR_TOKEN_MASK = 8'hE0;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic REQ_ARM  = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CRC_ERR   = 2'd1;
	localparam logic [1:0] ST_ERR_TOKEN = 2'd2;
	localparam logic [1:0] ST_UNKNOWN   = 2'd3;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CRCH = 3'd3;
	localparam logic [2:0] PH_CRCL = 3'd4;

	localparam logic REG_BLOCK_SIZE  = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	typedef struct packed {
		logic [BLOCK_SIZE_W-1:0] block_size;
		logic [RETRY_W-1:0]      token_retry_limit;
	} sdpr_cfg_t;

	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
		input logic [7:0] data);
		logic [CRC_W-1:0] crc;
		crc = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (crc[CRC_W-1]) begin
				crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[CRC_W-2:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

@@ hdl/sdpr_regs.sv @@
`timescale 1ns / 1ps

module sdpr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sdpr_pkg::PADDR_W-1:0]   paddr,
	input  logic [sdpr_pkg::PDATA_W-1:0]   pwdata,
	output logic [sdpr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output sdpr_pkg::sdpr_cfg_t            cfg
);
	import sdpr_pkg::*;

	sdpr_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size        <= RESET_BLOCK_SIZE;
			cfg_q.token_retry_limit <= RESET_RETRY_LIMIT;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BLOCK_SIZE:  cfg_q.block_size <= pwdata[BLOCK_SIZE_W-1:0];
				REG_RETRY_LIMIT: cfg_q.token_retry_limit <= pwdata[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BLOCK_SIZE:  prdata = {{(PDATA_W-BLOCK_SIZE_W){1'b0}}, cfg_q.block_size};
			REG_RETRY_LIMIT: prdata = {{(PDATA_W-RETRY_W){1'b0}}, cfg_q.token_retry_limit};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/sdpr_parser.sv @@
`timescale 1ns / 1ps

module sdpr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdpr_pkg::sdpr_cfg_t  cfg,
	input  logic                 valid_s1,
	input  logic                 req_type_s1,
	input  logic [7:0]           rx_byte_s1,
	output logic                 advance,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_status,
	output logic [7:0]           data_byte,
	output logic [1:0]           status_code,
	output logic [4:0]           error_bits,
	output logic                 last
);
	import sdpr_pkg::*;

	logic [2:0]              phase_q, phase_d;
	logic [RETRY_W-1:0]      retry_q, retry_d;
	logic [BLOCK_SIZE_W-1:0] bytes_q, bytes_d, bytes_dec, arm_size;
	logic [CRC_W-1:0]        crc_q, crc_d;
	logic [7:0]              crch_q, crch_d;

	logic       fire, res;
	logic       res_status;
	logic [7:0] res_data;
	logic [1:0] res_code;
	logic [4:0] res_bits;

	logic       out_valid_q, is_status_q, last_q;
	logic [7:0] data_byte_q;
	logic [1:0] status_code_q;
	logic [4:0] error_bits_q;

	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign bytes_dec = (bytes_q != '0) ? bytes_q - 1'b1 : '0;
	assign arm_size  = (cfg.block_size > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : cfg.block_size;

	always_comb begin
		phase_d    = phase_q;
		retry_d    = retry_q;
		bytes_d    = bytes_q;
		crc_d      = crc_q;
		crch_d     = crch_q;
		res        = 1'b0;
		res_status = 1'b1;
		res_data   = '0;
		res_code   = ST_OK;
		res_bits   = '0;
		if (req_type_s1 == REQ_ARM) begin
			phase_d = PH_WAIT;
			retry_d = cfg.token_retry_limit;
			bytes_d = arm_size;
			crc_d   = '0;
			crch_d  = '0;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (rx_byte_s1 == FILLER) begin
						if (retry_q == '0) begin
							res      = 1'b1;
							res_code = ST_UNKNOWN;
							phase_d  = PH_IDLE;
						end else begin
							retry_d = retry_q - 1'b1;
						end
					end else if (rx_byte_s1 == TOKEN_START) begin
						phase_d = (bytes_q == '0) ? PH_CRCH : PH_DATA;
					end else if ((rx_byte_s1 & ERR_TOKEN_MASK) == 8'h00) begin
						res      = 1'b1;
						res_code = ST_ERR_TOKEN;
						res_bits = rx_byte_s1[4:0];
						phase_d  = PH_IDLE;
					end else begin
						res      = 1'b1;
						res_code = ST_UNKNOWN;
						phase_d  = PH_IDLE;
					end
				end
				PH_DATA: begin
					crc_d      = crc_fold(crc_q, rx_byte_s1);
					bytes_d    = bytes_dec;
					if (bytes_dec == '0) begin
						phase_d = PH_CRCH;
					end
					res        = 1'b1;
					res_status = 1'b0;
					res_data   = rx_byte_s1;
				end
				PH_CRCH: begin
					crch_d  = rx_byte_s1;
					phase_d = PH_CRCL;
				end
				PH_CRCL: begin
					res      = 1'b1;
					res_code = ({crch_q, rx_byte_s1} == crc_q) ? ST_OK : ST_CRC_ERR;
					phase_d  = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			retry_q     <= '0;
			bytes_q     <= '0;
			crc_q       <= '0;
			crch_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res;
			if (fire) begin
				phase_q <= phase_d;
				retry_q <= retry_d;
				bytes_q <= bytes_d;
				crc_q   <= crc_d;
				crch_q  <= crch_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res) begin
			is_status_q   <= res_status;
			data_byte_q   <= res_data;
			status_code_q <= res_code;
			error_bits_q  <= res_bits;
			last_q        <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_status   = is_status_q;
	assign data_byte   = data_byte_q;
	assign status_code = status_code_q;
	assign error_bits  = error_bits_q;
	assign last        = last_q;

endmodule

@@ hdl/sd_spi_data_packet_receiver.sv @@
`timescale 1ns / 1ps

// Receives an SD card SPI-mode read data packet one word per cycle. An arm word
// (req_type 0) loads block_size (capped at 512) and token_retry_limit; byte words
// then skip up to limit filler bytes (one more filler times out), take the 0xFE
// start token, pass each data byte out and fold it into CRC16-XMODEM, and finish
// with one status word (ok, CRC mismatch, error token with its low five bits, or
// unknown/timeout). An accepted word is held in the input register, and its result
// is then loaded into the result register, from which it can be taken. A word is
// accepted each cycle unless the input register holds a word while a stalled
// result occupies the result register.

module sd_spi_data_packet_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sdpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sdpr_pkg::PDATA_W-1:0]  pwdata,
	output logic [sdpr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_status,
	output logic [7:0]                    data_byte,
	output logic [1:0]                    status_code,
	output logic [4:0]                    error_bits,
	output logic                          last
);
	import sdpr_pkg::*;

	sdpr_cfg_t  cfg;
	logic       valid_s1, req_type_s1, advance;
	logic [7:0] rx_byte_s1;

	sdpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	sdpr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.req_type_s1 (req_type_s1),
		.rx_byte_s1  (rx_byte_s1),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_status   (is_status),
		.data_byte   (data_byte),
		.status_code (status_code),
		.error_bits  (error_bits),
		.last        (last)
	);

endmodule

@@ hdl/sdpr_checker.sv @@
`timescale 1ns / 1ps

module sdpr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pready,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          is_status,
	input logic [7:0]                    data_byte,
	input logic [1:0]                    status_code,
	input logic [4:0]                    error_bits,
	input logic                          last
);
	import sdpr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(status_code)
			&& $stable(is_status) && $stable(error_bits) && $stable(last))
		else $error("held result word changed");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status_code == ST_OK && error_bits == '0 && !last)
		else $error("data word carries status fields");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> last && data_byte == 8'h00)
		else $error("status word without last or with data");

	a_err_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_code != ST_ERR_TOKEN |-> error_bits == '0)
		else $error("error bits outside an error token");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("access cycle without ready");

endmodule

bind sd_spi_data_packet_receiver sdpr_checker u_sdpr_checker (.*);
